/* rtl/core/htcf_pkg.sv */
// shared types and constants of the hostname ttl cache
package htcf_pkg;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_COUNT  = 2'd2;
  localparam logic [1:0] FUNC_FLUSH  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  localparam logic [1:0] REG_TTL = 2'd0;
  localparam logic [15:0] TTL_RESET = 16'd300;
  localparam logic [9:0] LIVE_MAX = 10'd1023;

  // per-slot record kept in the entry memory
  typedef struct packed {
    logic [7:0]  name_len;
    logic        is_v6;
    logic [31:0] ipv4;
    logic [63:0] ipv6_high;
    logic [63:0] ipv6_low;
    logic [32:0] expiry;
  } entry_t;
endpackage

/* rtl/core/hostname_ttl_cache_fnv_unit.sv */
// hostname ttl cache: direct-mapped name-to-address store with fnv-1a indexing
// Usage: pulse start with func and payload while busy is low; a transfer is
// taken on that edge. Lookup/insert stream one name byte per transfer; a
// non-last byte passes through the hash state and gives no result. On the
// last byte the slot record is read from a synchronous memory. A lookup
// checks the record (an early miss ends there), then compares the stored
// name one byte at a time (S_CMP, S_CMPCHK) against the name buffer memory;
// an insert copies the buffered name into the slot. Count walks every slot,
// one per cycle. Flush clears all valid bits.
// Each result is shown for one cycle with out_valid; the receiver cannot
// stall. busy falls as the result cycle begins, so the next transfer may be
// taken at the edge that ends it.
// Reset clears the valid bits (flip-flops) and the name length, and sets the hash to the basis.
// Memories have no reset: the name memory holds entries only ever read
// behind a valid bit. The cfg port is APB style, pready always high; register
// 0 (ttl_seconds) lies at byte address 0.
module hostname_ttl_cache_fnv_unit import htcf_pkg::*; #(
  parameter int CACHE_ENTRIES = 512,
  parameter int NAME_BYTES    = 255
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_func,
  input  logic [7:0]   in_host_byte,
  input  logic         in_host_last,
  input  logic         in_addr_is_v6,
  input  logic [31:0]  in_ipv4_addr,
  input  logic [63:0]  in_ipv6_high,
  input  logic [63:0]  in_ipv6_low,
  input  logic [31:0]  in_now_seconds,
  output logic         out_valid,
  output logic [1:0]   out_status,
  output logic         out_hit_is_v6,
  output logic [31:0]  out_hit_ipv4,
  output logic [63:0]  out_hit_ipv6_high,
  output logic [63:0]  out_hit_ipv6_low,
  output logic [9:0]   out_live_count,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam int LW = $clog2(NAME_BYTES + 2);
  localparam int BW = $clog2(NAME_BYTES);
  localparam int NW = IW + BW;
  localparam int CW = IW + 1;
  localparam logic [LW-1:0] LEN_LIMIT = LW'(NAME_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_RDENT, S_CHKENT, S_CMP, S_CMPCHK, S_INSWR, S_CNT, S_CNTLAST,
    S_DONE
  } state_t;

  state_t state_r;
  logic [15:0] ttl_r;
  logic [1:0] func_r;
  logic [7:0] byte_r;
  logic last_r, v6_r;
  logic [31:0] ipv4_r, now_r;
  logic [63:0] hi_r, lo_r;
  logic [LW-1:0] len_r;
  logic [BW-1:0] pos_r;
  logic [IW-1:0] slot_r;
  logic [CW-1:0] walk_r;
  logic [9:0] cnt_r;
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic cmp_ok_r;

  logic res_v_r;
  logic [1:0] res_st_r;
  logic res_v6_r;
  logic [31:0] res_ip4_r;
  logic [63:0] res_hi_r, res_lo_r;
  logic [9:0] res_cnt_r;

  // memories
  entry_t ent_mem [CACHE_ENTRIES];
  logic [7:0] ename_mem [CACHE_ENTRIES * NAME_BYTES];
  logic [7:0] nbuf_mem [NAME_BYTES];
  entry_t ent_q;
  logic [7:0] ename_q, nbuf_q;
  logic ent_we, ename_we, nbuf_we;
  logic [IW-1:0] ent_ra;
  logic [NW-1:0] ename_addr;
  logic [BW-1:0] nbuf_ra;
  entry_t ent_wd;

  logic [31:0] hash;
  logic hash_restart, hash_step;
  logic accept;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TTL) ? {16'd0, ttl_r} : 32'd0;

  htcf_hash u_hash (
    .clk(clk), .rst_n(rst_n), .restart(hash_restart), .step(hash_step),
    .din(byte_r), .hash(hash)
  );

  logic [NW-1:0] slot_base;
  assign slot_base = NW'(slot_r) * NW'(NAME_BYTES);

  always_comb begin
    hash_step = (state_r == S_HASH);
    hash_restart = 1'b0;
    ent_ra = hash[IW-1:0];
    if (state_r == S_CNT || state_r == S_CNTLAST) ent_ra = walk_r[IW-1:0];
    nbuf_we = (state_r == S_HASH) && (len_r < LEN_LIMIT);
    nbuf_ra = pos_r;
    ename_addr = slot_base + NW'(pos_r);
    ename_we = (state_r == S_INSWR);
    ent_we = (state_r == S_INSWR) && (pos_r == BW'(0));
    ent_wd.name_len = 8'(len_r);
    ent_wd.is_v6 = v6_r;
    ent_wd.ipv4 = ipv4_r;
    ent_wd.ipv6_high = hi_r;
    ent_wd.ipv6_low = lo_r;
    ent_wd.expiry = {1'b0, now_r} + {17'd0, ttl_r};
    if (state_r == S_DONE && func_r[1] == 1'b0 && last_r) hash_restart = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (nbuf_we) nbuf_mem[len_r[BW-1:0]] <= byte_r;
    nbuf_q <= nbuf_mem[nbuf_ra];
    if (ename_we) ename_mem[ename_addr] <= nbuf_q;
    ename_q <= ename_mem[ename_addr];
    if (ent_we) ent_mem[slot_r] <= ent_wd;
    ent_q <= ent_mem[ent_ra];
  end

  logic live;
  assign live = valid_r[walk_r[IW-1:0] - IW'(1)] && ({1'b0, now_r} < ent_q.expiry);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ttl_r <= TTL_RESET;
      len_r <= '0;
      valid_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= (state_r == S_DONE);
      if (psel && penable && pwrite && paddr == REG_TTL) ttl_r <= pwdata[15:0];
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r <= in_func; byte_r <= in_host_byte; last_r <= in_host_last;
            v6_r <= in_addr_is_v6; ipv4_r <= in_ipv4_addr; hi_r <= in_ipv6_high;
            lo_r <= in_ipv6_low; now_r <= in_now_seconds;
            res_st_r <= ST_OK; res_v6_r <= 1'b0; res_ip4_r <= '0;
            res_hi_r <= '0; res_lo_r <= '0; res_cnt_r <= '0;
            walk_r <= '0; cnt_r <= '0;
            case (in_func)
              FUNC_COUNT: state_r <= S_CNT;
              FUNC_FLUSH: begin valid_r <= '0; state_r <= S_DONE; end
              default: state_r <= S_HASH;
            endcase
          end
        end
        S_HASH: begin
          if (len_r <= LEN_LIMIT) len_r <= len_r + LW'(1);
          if (!last_r) state_r <= S_IDLE;
          else if (len_r >= LEN_LIMIT) begin
            res_st_r <= ST_TOOLONG; state_r <= S_DONE;
          end else state_r <= S_RDENT;
        end
        S_RDENT: begin
          // hash now final; entry read issued this cycle
          slot_r <= hash[IW-1:0];
          pos_r <= '0;
          cmp_ok_r <= 1'b1;
          state_r <= (func_r == FUNC_INSERT) ? S_CMP : S_CHKENT;
        end
        S_CHKENT: begin
          if (!valid_r[slot_r] || ent_q.name_len != 8'(len_r)
              || !({1'b0, now_r} < ent_q.expiry)) begin
            res_st_r <= ST_MISS; state_r <= S_DONE;
          end else state_r <= S_CMP;
        end
        S_CMP: begin
          // reads of both name bytes at pos_r in flight
          state_r <= (func_r == FUNC_INSERT) ? S_INSWR : S_CMPCHK;
        end
        S_CMPCHK: begin
          if (ename_q != nbuf_q) cmp_ok_r <= 1'b0;
          if (LW'(pos_r) + LW'(1) >= len_r) begin
            if (ename_q != nbuf_q || !cmp_ok_r) res_st_r <= ST_MISS;
            else begin
              res_v6_r <= ent_q.is_v6;
              res_ip4_r <= ent_q.is_v6 ? 32'd0 : ent_q.ipv4;
              res_hi_r <= ent_q.is_v6 ? ent_q.ipv6_high : 64'd0;
              res_lo_r <= ent_q.is_v6 ? ent_q.ipv6_low : 64'd0;
            end
            state_r <= S_DONE;
          end else begin
            pos_r <= pos_r + BW'(1); state_r <= S_CMP;
          end
        end
        S_INSWR: begin
          if (pos_r == BW'(0)) valid_r[slot_r] <= 1'b1;
          if (LW'(pos_r) + LW'(1) >= len_r) state_r <= S_DONE;
          else begin pos_r <= pos_r + BW'(1); state_r <= S_CMP; end
        end
        S_CNT: begin
          walk_r <= walk_r + CW'(1);
          if (walk_r != '0 && live && cnt_r != LIVE_MAX) cnt_r <= cnt_r + 10'd1;
          if (walk_r == CW'(CACHE_ENTRIES - 1)) state_r <= S_CNTLAST;
        end
        S_CNTLAST: begin
          // walk_r is CACHE_ENTRIES here; its index - 1 wraps to the last slot
          if (live && cnt_r != LIVE_MAX) res_cnt_r <= cnt_r + 10'd1;
          else res_cnt_r <= cnt_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (func_r[1] == 1'b0) len_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = res_v_r;
  assign out_status = res_st_r;
  assign out_hit_is_v6 = res_v6_r;
  assign out_hit_ipv4 = res_ip4_r;
  assign out_hit_ipv6_high = res_hi_r;
  assign out_hit_ipv6_low = res_lo_r;
  assign out_live_count = res_cnt_r;

  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !busy) else $error("result while busy");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_FLUSH) |=> valid_r == '0) else $error("flush left valid");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_LIMIT + LW'(1)) else $error("name length overrun");
endmodule

/* rtl/core/htcf_hash.sv */
// fnv-1a hash step, one name byte folded in per enabled cycle
module htcf_hash import htcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        restart,
  input  logic        step,
  input  logic [7:0]  din,
  output logic [31:0] hash
);
  logic [31:0] hash_r, hash_nxt;

  always_comb begin
    hash_nxt = hash_r;
    if (restart) hash_nxt = FNV_BASIS;
    else if (step) hash_nxt = (hash_r ^ {24'd0, din}) * FNV_PRIME;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hash_r <= FNV_BASIS;
    else hash_r <= hash_nxt;
  end

  assign hash = hash_r;
endmodule
